[rtl/text_console_writer_unit_macros.svh]
// ----------------------------------------------------------------------------
// text console writer assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// checked outside reset
`define TCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked in every cycle, reset included
`define TCW_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_RST(label, prop, msg)

`endif

`endif

[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, codes and command type of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int TCW_ROWS    = 25;
  localparam int TCW_COLUMNS = 80;

  localparam int TCW_ACTION_W = 2;
  localparam int TCW_CHAR_W   = 8;
  localparam int TCW_ROW_W    = 5;
  localparam int TCW_COL_W    = 7;
  localparam int TCW_CELL_W   = 16;
  localparam int TCW_COLOR_W  = 8;

  localparam int TCW_CMD_DEPTH = 2;

  // action codes
  localparam logic [TCW_ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [TCW_ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [TCW_ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [TCW_CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [TCW_CHAR_W-1:0] SPACE_CODE   = 8'h20;

  localparam logic [3:0] FG_GREY = 4'd7;
  localparam logic [3:0] BLACK   = 4'd0;

  localparam logic [TCW_COLOR_W-1:0] RESET_COLOR = {BLACK, FG_GREY};
  localparam logic [TCW_CELL_W-1:0]  BLANK_CELL  = {RESET_COLOR, SPACE_CODE};
  localparam logic [TCW_CELL_W-1:0]  SCROLL_FILL = {8'h00, SPACE_CODE};

  // command kinds decided by the front end
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_NOP      = 3'd0;
  localparam kind_t KIND_CHAR     = 3'd1;
  localparam kind_t KIND_NEWLINE  = 3'd2;
  localparam kind_t KIND_READ     = 3'd3;
  localparam kind_t KIND_READ_OUT = 3'd4;
  localparam kind_t KIND_CLEAR    = 3'd5;

  typedef struct packed {
    kind_t                 kind;
    logic [TCW_CHAR_W-1:0] char_code;
    logic [TCW_ROW_W-1:0]  cell_row;
    logic [TCW_COL_W-1:0]  cell_column;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// Classifies an incoming item into a command kind for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int ROWS    = tcw_pkg::TCW_ROWS,
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS
) (
  input  wire logic [tcw_pkg::TCW_ACTION_W-1:0] action,
  input  wire logic [tcw_pkg::TCW_CHAR_W-1:0]   char_code,
  input  wire logic [tcw_pkg::TCW_ROW_W-1:0]    cell_row,
  input  wire logic [tcw_pkg::TCW_COL_W-1:0]    cell_column,
  output tcw_pkg::cmd_t                         cmd
);
  import tcw_pkg::*;

  logic in_range;

  assign in_range = (32'(cell_row) < ROWS) && (32'(cell_column) < COLUMNS);

  always_comb begin
    cmd.char_code   = char_code;
    cmd.cell_row    = cell_row;
    cmd.cell_column = cell_column;
    case (action)
      ACT_PUT: begin
        cmd.kind = (char_code == NEWLINE_CODE) ? KIND_NEWLINE : KIND_CHAR;
      end
      ACT_READ: begin
        // reads off the screen give zero without touching the store
        cmd.kind = in_range ? KIND_READ : KIND_READ_OUT;
      end
      ACT_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      default: begin
        cmd.kind = KIND_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/tcw_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tcw_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cmd_fifo (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire tcw_pkg::cmd_t push_data,
  output logic              full,
  input  wire logic         pop,
  output tcw_pkg::cmd_t     pop_data,
  output logic              empty
);
  import tcw_pkg::*;

  localparam int PTR_W = (TCW_CMD_DEPTH > 1) ? $clog2(TCW_CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(TCW_CMD_DEPTH + 1);

  cmd_t             slots [TCW_CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(TCW_CMD_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(TCW_CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(TCW_CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// Command sequencer: screen store, cursor, scroll and fill sweeps, result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_writer_unit_macros.svh"

module tcw_back #(
  parameter int ROWS    = tcw_pkg::TCW_ROWS,
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [tcw_pkg::TCW_COLOR_W-1:0] color,
  input  wire tcw_pkg::cmd_t                  cmd,
  input  wire logic                           cmd_empty,
  output logic                                cmd_pop,
  output logic                                init_busy,
  input  wire logic                           pop,
  output logic                                empty,
  output logic [tcw_pkg::TCW_CELL_W-1:0]      cell_value,
  output logic [tcw_pkg::TCW_ROW_W-1:0]       cursor_row,
  output logic [tcw_pkg::TCW_COL_W-1:0]       cursor_column
);
  import tcw_pkg::*;

  localparam int CELLS         = ROWS * COLUMNS;
  localparam int AW            = $clog2(CELLS);
  localparam int RW            = $clog2(ROWS);
  localparam int CW            = $clog2(COLUMNS);
  localparam int PW            = $clog2(CELLS + 1);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam logic [1:0] S_FILL   = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_SCROLL = 2'd3;

  logic [1:0]            state;
  logic [RW-1:0]         row;
  logic [CW-1:0]         col;
  logic [AW-1:0]         row_base;
  logic [AW-1:0]         fill_addr;
  logic [TCW_CELL_W-1:0] fill_data;
  logic                  fill_report;
  logic [PW-1:0]         src;
  logic                  wr_pend;
  logic [AW-1:0]         wr_addr;
  logic                  out_valid;
  logic [TCW_CELL_W-1:0] out_cell;
  logic [RW-1:0]         out_row;
  logic [CW-1:0]         out_col;

  logic [TCW_CELL_W-1:0] mem [CELLS];
  logic [TCW_CELL_W-1:0] rd_data;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [TCW_CELL_W-1:0] mem_wd;
  logic [AW-1:0]         mem_ra;
  logic [AW-1:0]         rd_addr;

  logic [RW-1:0]         row_next;
  logic [CW-1:0]         col_next;
  logic [AW-1:0]         row_base_next;
  logic                  scroll_start;
  logic                  last_row;

  assign cmd_pop       = (state == S_IDLE) && !cmd_empty && (!out_valid || pop);
  assign init_busy     = (state == S_FILL) && !fill_report;
  assign empty         = !out_valid;
  assign cell_value    = out_cell;
  assign cursor_row    = TCW_ROW_W'(out_row);
  assign cursor_column = TCW_COL_W'(out_col);

  assign rd_addr  = AW'(32'(cmd.cell_row) * COLUMNS + 32'(cmd.cell_column));
  assign last_row = (row == RW'(ROWS - 1));

  // cursor after a character or a newline
  always_comb begin
    row_next      = row;
    col_next      = col;
    row_base_next = row_base;
    scroll_start  = 1'b0;
    if (cmd.kind == KIND_CHAR && col != CW'(COLUMNS - 1)) begin
      col_next = col + 1'b1;
    end else begin
      col_next = '0;
      if (last_row) begin
        scroll_start  = 1'b1;
        row_base_next = AW'(LAST_ROW_BASE);
      end else begin
        row_next      = row + 1'b1;
        row_base_next = row_base + AW'(COLUMNS);
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_addr;
    mem_wd = fill_data;
    mem_ra = rd_addr;
    case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (cmd_pop && cmd.kind == KIND_CHAR) begin
          mem_we = 1'b1;
          mem_wa = row_base + AW'(col);
          mem_wd = {color, cmd.char_code};
        end
      end
      S_SCROLL: begin
        // copy one row up: read ahead by one row, write back the registered read data
        mem_we = wr_pend;
        mem_wa = wr_addr;
        mem_wd = rd_data;
        mem_ra = AW'(src);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      fill_addr   <= '0;
      fill_data   <= BLANK_CELL;
      fill_report <= 1'b0;
      row         <= '0;
      col         <= '0;
      row_base    <= '0;
      src         <= '0;
      wr_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FILL: begin
          fill_addr <= fill_addr + 1'b1;
          if (fill_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
            if (fill_report) begin
              out_valid <= 1'b1;
              out_cell  <= '0;
              out_row   <= row;
              out_col   <= col;
            end
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              KIND_CHAR, KIND_NEWLINE: begin
                row      <= row_next;
                col      <= col_next;
                row_base <= row_base_next;
                if (scroll_start) begin
                  state       <= S_SCROLL;
                  src         <= PW'(COLUMNS);
                  wr_pend     <= 1'b0;
                  fill_addr   <= AW'(LAST_ROW_BASE);
                  fill_data   <= SCROLL_FILL;
                  fill_report <= 1'b1;
                end else begin
                  out_valid <= 1'b1;
                  out_cell  <= '0;
                  out_row   <= row_next;
                  out_col   <= col_next;
                end
              end
              KIND_READ: begin
                state <= S_READ;
              end
              KIND_CLEAR: begin
                row         <= '0;
                col         <= '0;
                row_base    <= '0;
                fill_addr   <= '0;
                fill_data   <= {color, SPACE_CODE};
                fill_report <= 1'b1;
                state       <= S_FILL;
              end
              default: begin
                out_valid <= 1'b1;
                out_cell  <= '0;
                out_row   <= row;
                out_col   <= col;
              end
            endcase
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
          out_cell  <= rd_data;
          out_row   <= row;
          out_col   <= col;
        end
        S_SCROLL: begin
          if (src == PW'(CELLS)) begin
            wr_pend <= 1'b0;
            state   <= S_FILL;
          end else begin
            wr_pend <= 1'b1;
            wr_addr <= AW'(src - PW'(COLUMNS));
            src     <= src + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TCW_ASSERT_RST(a_reset_starts_sweep, rst |=> state == S_FILL && !out_valid, "reset missed the sweep")
  `TCW_ASSERT(a_busy_no_result, state != S_IDLE |-> !out_valid, "result held while busy")
  `TCW_ASSERT(a_cursor_range, (32'(row) < ROWS) && (32'(col) < COLUMNS), "cursor off screen")
  `TCW_ASSERT(a_row_base, row_base == AW'(32'(row) * COLUMNS), "row base out of step")
  `TCW_ASSERT(a_scroll_cursor, state == S_SCROLL |-> last_row && col == '0, "scroll cursor wrong")

endmodule

`default_nettype wire

[rtl/text_console_writer_unit.sv]
// Text console writer. Items go in through a push/full queue port and one
// result per item comes out through an empty/pop port. Characters, newlines,
// off-screen reads and unused actions are done in the sequencer's idle state;
// a screen read adds a read state (registered store read). A clear sweeps all
// cells and a scroll copies the rows up and fills the last row with spaces,
// both through the single write port of the screen store. After reset all
// ROWS*COLUMNS cells (2000 by default) are swept to blanks, while full stays
// high; colour writes are taken at any time. A two-entry command queue lets
// input keep flowing while the sequencer is busy or a result waits.
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Top level: colour register, front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit #(
  parameter int ROWS    = tcw_pkg::TCW_ROWS,
  parameter int COLUMNS = tcw_pkg::TCW_COLUMNS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [tcw_pkg::TCW_ACTION_W-1:0] action,
  input  wire logic [tcw_pkg::TCW_CHAR_W-1:0]   char_code,
  input  wire logic [tcw_pkg::TCW_ROW_W-1:0]    cell_row,
  input  wire logic [tcw_pkg::TCW_COL_W-1:0]    cell_column,
  input  wire logic                             pop,
  output logic                                  empty,
  output logic [tcw_pkg::TCW_CELL_W-1:0]        cell_value,
  output logic [tcw_pkg::TCW_ROW_W-1:0]         cursor_row,
  output logic [tcw_pkg::TCW_COL_W-1:0]         cursor_column,
  input  wire logic                             text_color_write,
  input  wire logic [tcw_pkg::TCW_COLOR_W-1:0]  text_color
);
  import tcw_pkg::*;

  logic [TCW_COLOR_W-1:0] color;
  cmd_t                   front_cmd;
  cmd_t                   queue_cmd;
  logic                   queue_full;
  logic                   queue_empty;
  logic                   queue_pop;
  logic                   init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= RESET_COLOR;
    end else if (text_color_write) begin
      color <= text_color;
    end
  end

  // no transfer in while the store is being swept after reset
  assign full = queue_full || init_busy;

  tcw_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .action      (action),
    .char_code   (char_code),
    .cell_row    (cell_row),
    .cell_column (cell_column),
    .cmd         (front_cmd)
  );

  tcw_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push && !init_busy),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (queue_cmd),
    .empty     (queue_empty)
  );

  tcw_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .color         (color),
    .cmd           (queue_cmd),
    .cmd_empty     (queue_empty),
    .cmd_pop       (queue_pop),
    .init_busy     (init_busy),
    .pop           (pop),
    .empty         (empty),
    .cell_value    (cell_value),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column)
  );

endmodule

`default_nettype wire
